@@ sv/assert_macros.svh @@
// Assertion macros shared by the name decompressor modules.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing when the design is synthesized.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define DNSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition in one cycle that implies a condition in the next cycle.
`define DNSD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);
`else
`define DNSD_ASSERT(lbl, clk, rstn, prop, msg)
`define DNSD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

@@ sv/dnsd_pkg.sv @@
`timescale 1ns / 1ps
package dnsd_pkg;

  // Command codes of the input channel.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Field widths fixed by the interface.
  localparam int OFFSET_W = 11;
  localparam int LEN_W    = 12;
  localparam int BYTE_W   = 8;

  // Walk position width: holds a 14-bit pointer target and a label end.
  localparam int POS_W = 15;

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 2;

  // Top two bits of a pointer byte.
  localparam logic [1:0] PTR_TAG = 2'b11;

  // One classified command on its way from the front to the back.
  typedef struct packed {
    logic                cmd;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   byte_value;
    logic [LEN_W-1:0]    len;     // message length, clamped to the store
    logic                wr_ok;   // load address lies inside the store
  } dnsd_item_t;

endpackage

@@ sv/dnsd_ram.sv @@
`timescale 1ns / 1ps
module dnsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/dnsd_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dnsd_front #(
  parameter int MSG_BYTES = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [dnsd_pkg::OFFSET_W-1:0] in_offset,
  input  logic [dnsd_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic [dnsd_pkg::LEN_W-1:0]   in_msg_length,
  output logic                         q_valid,
  output dnsd_pkg::dnsd_item_t         q_item,
  input  logic                         q_pop
);
  import dnsd_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  dnsd_item_t      q_mem_r [Q_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push;
  dnsd_item_t      item;

  // Classify the command: clamp the length and flag loads outside the store.
  always_comb begin
    item.cmd        = in_cmd;
    item.offset     = in_offset;
    item.byte_value = in_byte_value;
    item.wr_ok      = (32'(in_offset) < 32'(MSG_BYTES));
    if (32'(in_msg_length) > 32'(MSG_BYTES)) begin
      item.len = LEN_W'(MSG_BYTES);
    end else begin
      item.len = in_msg_length;
    end
  end

  assign busy    = (cnt_r == CW'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= item;
    end
  end

  `DNSD_ASSERT(a_q_cnt_range, clk, rst_n, cnt_r <= CW'(Q_DEPTH), "queue count overflow")
  `DNSD_ASSERT(a_pop_nonempty, clk, rst_n, !q_pop || (cnt_r != '0), "pop from empty queue")
  `DNSD_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !q_pop, cnt_r == $past(cnt_r) + 1'b1, "push lost")

endmodule

@@ sv/dnsd_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dnsd_back #(
  parameter int MSG_BYTES     = 2048,
  parameter int NAME_CHARS    = 255,
  parameter int POINTER_LIMIT = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  dnsd_pkg::dnsd_item_t        q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [31:0]                 out_name_bytes,
  output logic [2:0]                  out_byte_count,
  output logic                        out_last,
  output logic [dnsd_pkg::LEN_W-1:0]  out_next_offset,
  output logic                        out_status
);
  import dnsd_pkg::*;

  localparam int AW = $clog2(MSG_BYTES);
  localparam int WW = $clog2(NAME_CHARS);
  localparam int GW = $clog2(POINTER_LIMIT + 1);
  localparam logic [WW-1:0] CAP   = WW'(NAME_CHARS - 1);
  localparam logic [GW-1:0] GLIM  = GW'(POINTER_LIMIT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_TAG   = 3'd2;
  localparam logic [2:0] ST_PTR   = 3'd3;
  localparam logic [2:0] ST_LABEL = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [WW-1:0]    w_r, w_nxt;
  logic             jumped_r, jumped_nxt;
  logic             ok_r, ok_nxt;
  logic [LEN_W-1:0] ret_r, ret_nxt;
  logic [GW-1:0]    guard_r, guard_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [5:0]       hi_r, hi_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [2:0]       cnt_r, cnt_nxt;

  logic             out_valid_r;
  logic [31:0]      out_word_r;
  logic [2:0]       out_cnt_r;
  logic             out_last_r;
  logic [LEN_W-1:0] out_noff_r;
  logic             out_status_r;

  logic             we, re;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;

  logic             app;
  logic [7:0]       app_ch;
  logic             emit, emit_last, fin_ok;
  logic [LEN_W-1:0] fin_ret;
  logic [31:0]      emit_word;
  logic [2:0]       emit_cnt;
  logic [POS_W-1:0] pos_inc, lbl_end, len_ext;

  dnsd_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(q_item.offset)),
    .wdata (q_item.byte_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_inc = pos_r + 1'b1;
  assign lbl_end = pos_inc + POS_W'(rdata);
  assign len_ext = POS_W'(len_r);

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    jumped_nxt = jumped_r;
    ok_nxt     = ok_r;
    ret_nxt    = ret_r;
    guard_nxt  = guard_r;
    rem_nxt    = rem_r;
    hi_nxt     = hi_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    raddr      = AW'(pos_r);
    app        = 1'b0;
    app_ch     = 8'h2e;
    emit_last  = 1'b0;
    fin_ok     = 1'b0;
    fin_ret    = ret_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.cmd == CMD_LOAD) begin
            we = q_item.wr_ok;
          end else begin
            pos_nxt    = POS_W'(q_item.offset);
            len_nxt    = q_item.len;
            jumped_nxt = 1'b0;
            ok_nxt     = 1'b0;
            ret_nxt    = '0;
            guard_nxt  = '0;
            state_nxt  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (pos_r >= len_ext) begin
          emit_last = 1'b1;
          fin_ok    = ok_r;
          state_nxt = ST_IDLE;
        end else begin
          re        = 1'b1;
          state_nxt = ST_TAG;
        end
      end
      ST_TAG: begin
        if (rdata[7:6] == PTR_TAG) begin
          if (pos_inc >= len_ext) begin
            emit_last = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            if (!jumped_r) begin
              ret_nxt = LEN_W'(pos_r + POS_W'(2));
              ok_nxt  = 1'b1;
            end
            hi_nxt    = rdata[5:0];
            re        = 1'b1;
            raddr     = AW'(pos_inc);
            state_nxt = ST_PTR;
          end
        end else if (rdata == 8'h00) begin
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
          if (!jumped_r) begin
            fin_ret = LEN_W'(pos_inc);
            fin_ok  = 1'b1;
          end else begin
            fin_ok  = ok_r;
          end
        end else if (lbl_end > len_ext) begin
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          app       = (w_r != '0) && (w_r < CAP);
          pos_nxt   = pos_inc;
          rem_nxt   = rdata;
          re        = 1'b1;
          raddr     = AW'(pos_inc);
          state_nxt = ST_LABEL;
        end
      end
      ST_PTR: begin
        if (guard_r == GLIM) begin
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          guard_nxt  = guard_r + 1'b1;
          jumped_nxt = 1'b1;
          pos_nxt    = POS_W'({hi_r, rdata});
          state_nxt  = ST_FETCH;
        end
      end
      ST_LABEL: begin
        app     = (w_r < CAP);
        app_ch  = rdata;
        pos_nxt = pos_inc;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == 8'd1) begin
          state_nxt = ST_FETCH;
        end else begin
          re    = 1'b1;
          raddr = AW'(pos_inc);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Character packing. A full word is held back until the next character
  // shows it is not the final one.
  always_comb begin
    w_nxt     = w_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    emit      = emit_last;
    emit_word = word_r;
    emit_cnt  = cnt_r;
    if (state_r == ST_IDLE) begin
      w_nxt    = '0;
      word_nxt = '0;
      cnt_nxt  = '0;
    end else if (app) begin
      w_nxt = w_r + 1'b1;
      if (cnt_r == 3'd4) begin
        emit     = 1'b1;
        word_nxt = {app_ch, 24'h0};
        cnt_nxt  = 3'd1;
      end else begin
        case (cnt_r[1:0])
          2'd0:    word_nxt = {app_ch, word_r[23:0]};
          2'd1:    word_nxt = {word_r[31:24], app_ch, word_r[15:0]};
          2'd2:    word_nxt = {word_r[31:16], app_ch, word_r[7:0]};
          default: word_nxt = {word_r[31:8], app_ch};
        endcase
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    len_r    <= len_nxt;
    w_r      <= w_nxt;
    jumped_r <= jumped_nxt;
    ok_r     <= ok_nxt;
    ret_r    <= ret_nxt;
    guard_r  <= guard_nxt;
    rem_r    <= rem_nxt;
    hi_r     <= hi_nxt;
    word_r   <= word_nxt;
    cnt_r    <= cnt_nxt;
    if (emit) begin
      out_word_r   <= emit_word;
      out_cnt_r    <= emit_cnt;
      out_last_r   <= emit_last;
      out_noff_r   <= (emit_last && fin_ok) ? fin_ret : '0;
      out_status_r <= emit_last && !fin_ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_name_bytes  = out_word_r;
  assign out_byte_count  = out_cnt_r;
  assign out_last        = out_last_r;
  assign out_next_offset = out_noff_r;
  assign out_status      = out_status_r;

  `DNSD_ASSERT(a_mid_full, clk, rst_n, !(out_valid && !out_last) || (out_byte_count == 3'd4), "partial word before the end of a name")
  `DNSD_ASSERT(a_mid_clean, clk, rst_n, !(out_valid && !out_last) || (!out_status && (out_next_offset == '0)), "status on a non-final result")
  `DNSD_ASSERT(a_err_offset, clk, rst_n, !(out_valid && out_status) || (out_next_offset == '0), "offset reported with an error")
  `DNSD_ASSERT(a_pop_idle, clk, rst_n, !q_pop || (state_r == ST_IDLE), "queue popped during a walk")

endmodule

@@ sv/dns_name_decompressor.sv @@
`timescale 1ns / 1ps
// DNS name decompressor. Commands enter on the in_ ports and are taken on a
// rising edge where start is high and busy is low. A load transaction writes
// one packet byte into the internal packet store; a decode transaction walks
// the name at in_offset, following compression pointers, and produces the
// dotted name four characters per result on the out_ ports. Each result is
// shown for one cycle with out_valid high; the receiver cannot stall, so
// results are never held. The result with out_last high carries the offset
// just past the name, or out_status high for a malformed name or a loop.
// A load is done by the back end when it leaves the queue. A decode walks
// the name label by label and pointer by pointer, paced by the single read
// port of the packet store; a pointer loop runs until the pointer limit
// ends it. With the walker idle, an accepted decode passes through the
// command queue and the walker's fetch state before out_valid rises, and
// also through its tag state when the name ends at its first byte.
// A two-entry command queue lets new transactions be taken while a walk is
// in progress; busy is high only when that queue is full. Reset empties the
// queue and returns the walker to idle; the packet store is not cleared and
// must be loaded before it is decoded.
module dns_name_decompressor #(
  parameter int MSG_BYTES     = 2048,
  parameter int NAME_CHARS    = 255,
  parameter int POINTER_LIMIT = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [dnsd_pkg::OFFSET_W-1:0] in_offset,
  input  logic [dnsd_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic [dnsd_pkg::LEN_W-1:0]   in_msg_length,
  output logic                         out_valid,
  output logic [31:0]                  out_name_bytes,
  output logic [2:0]                   out_byte_count,
  output logic                         out_last,
  output logic [dnsd_pkg::LEN_W-1:0]   out_next_offset,
  output logic                         out_status
);
  import dnsd_pkg::*;

  // Classified commands waiting for the walker.
  dnsd_item_t q_item;
  logic       q_valid;
  logic       q_pop;

  // The front end clamps the message length, checks load addresses and
  // queues the transaction.
  dnsd_front #(.MSG_BYTES(MSG_BYTES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_offset     (in_offset),
    .in_byte_value (in_byte_value),
    .in_msg_length (in_msg_length),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // The back end owns the packet store, performs loads and walks names.
  dnsd_back #(
    .MSG_BYTES     (MSG_BYTES),
    .NAME_CHARS    (NAME_CHARS),
    .POINTER_LIMIT (POINTER_LIMIT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_name_bytes  (out_name_bytes),
    .out_byte_count  (out_byte_count),
    .out_last        (out_last),
    .out_next_offset (out_next_offset),
    .out_status      (out_status)
  );

endmodule

@@ test/dns_name_decompressor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the DNS name decompressor.
//
// The bench keeps its own image of the packet store, loaded in step with
// every accepted load transaction, and its own name walker. For each decode
// transaction the walker produces the chunks (four characters per result)
// that the block must emit. The monitor checks them in order, one field at
// a time. A short directed table comes first, then random traffic made
// mostly of well-formed names with random content and pointer chains, mixed
// with stray bytes that break the names already in the store.
module dns_name_decompressor_tb;

  localparam int MSG_BYTES     = 2048;
  localparam int NAME_CHARS    = 255;
  localparam int POINTER_LIMIT = 128;

  // The walker keeps at most this many characters of a name.
  localparam int NAME_CAP = NAME_CHARS - 1;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam int RANDOM_ITEMS = 255;

  // A pointer loop that runs through long labels can keep the block busy
  // without a single result until the jump limit trips, so this is generous.
  // It only matters when the block hangs.
  localparam int STALL_LIMIT = 200000;

  // Roughly the longest walk of a full-length name, plus slack.
  localparam int DRAIN_CYCLES = 300;

  // One result of a decode transaction.
  typedef struct packed {
    logic [31:0] name_bytes;
    logic [2:0]  byte_count;
    logic        last;
    logic [11:0] next_offset;
    logic        status;
  } name_chunk_t;

  // One row of the directed table. Rows with typed set carry their single
  // expected result; the others are checked against the walker.
  typedef struct packed {
    logic                          cmd;
    logic [dnsd_pkg::OFFSET_W-1:0] offset;
    logic [dnsd_pkg::BYTE_W-1:0]   byte_value;
    logic [dnsd_pkg::LEN_W-1:0]    msg_length;
    logic                          typed;
    name_chunk_t                   want;
  } plan_row_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          start         = 1'b0;
  logic                          in_cmd        = dnsd_pkg::CMD_LOAD;
  logic [dnsd_pkg::OFFSET_W-1:0] in_offset     = '0;
  logic [dnsd_pkg::BYTE_W-1:0]   in_byte_value = '0;
  logic [dnsd_pkg::LEN_W-1:0]    in_msg_length = '0;
  logic                          busy;
  logic                          out_valid;
  logic [31:0]                   out_name_bytes;
  logic [2:0]                    out_byte_count;
  logic                          out_last;
  logic [dnsd_pkg::LEN_W-1:0]    out_next_offset;
  logic                          out_status;

  // Bench copy of the packet store. packet_known marks the bytes that have
  // been loaded; a decode that would read any other byte is never sent.
  logic [7:0]  packet_img   [MSG_BYTES];
  bit          packet_known [MSG_BYTES];

  // Bytes 0 .. fill_top-1 are all loaded, so any decode whose length does
  // not pass fill_top is safe to send.
  int unsigned fill_top = 0;

  // Offsets where a name was deliberately laid down.
  int unsigned name_heads[$];

  name_chunk_t chunks_due[$];   // results still owed by the block, oldest first
  name_chunk_t walk_chunks[$];  // output of the last walk
  name_chunk_t due_chunk;
  bit          walk_hit_unknown;

  plan_row_t   plan[$];
  int unsigned sent_items   = 0;
  int unsigned idle_pct     = 17;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;

  dns_name_decompressor #(
    .MSG_BYTES    (MSG_BYTES),
    .NAME_CHARS   (NAME_CHARS),
    .POINTER_LIMIT(POINTER_LIMIT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_offset      (in_offset),
    .in_byte_value  (in_byte_value),
    .in_msg_length  (in_msg_length),
    .out_valid      (out_valid),
    .out_name_bytes (out_name_bytes),
    .out_byte_count (out_byte_count),
    .out_last       (out_last),
    .out_next_offset(out_next_offset),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] peek_packet(input int unsigned addr);
    if (!packet_known[addr]) walk_hit_unknown = 1'b1;
    return packet_img[addr];
  endfunction

  // Walks the name at from_pos over the bench image and leaves the chunks
  // the block must emit in walk_chunks. Every byte read lies below the
  // clamped length, so a read past the store cannot happen.
  function automatic void walk_name(input int unsigned from_pos, input int unsigned msg_len);
    int unsigned pos, lim, ret, hops, k, i, nres;
    logic [7:0]  c;
    logic [7:0]  text[$];
    bit          jumped, ok, bad;
    name_chunk_t chunk;
    pos    = from_pos;
    lim    = (msg_len > MSG_BYTES) ? MSG_BYTES : msg_len;
    ret    = 0;
    hops   = 0;
    jumped = 1'b0;
    ok     = 1'b0;
    bad    = 1'b0;
    walk_chunks.delete();
    walk_hit_unknown = 1'b0;
    while (pos < lim) begin
      c = peek_packet(pos);
      if (c[7:6] == dnsd_pkg::PTR_TAG) begin
        // A pointer needs its second byte inside the message.
        if (pos + 1 >= lim) begin
          bad = 1'b1;
          break;
        end
        // The name ends in the packet just past the first pointer taken.
        if (!jumped) begin
          ret = pos + 2;
          ok  = 1'b1;
        end
        pos = {c[5:0], peek_packet(pos + 1)};
        hops++;
        if (hops > POINTER_LIMIT) begin
          bad = 1'b1;
          break;
        end
        jumped = 1'b1;
        continue;
      end
      if (c == 8'h00) begin
        if (!jumped) begin
          ret = pos + 1;
          ok  = 1'b1;
        end
        break;
      end
      pos++;
      if (pos + c > lim) begin
        bad = 1'b1;
        break;
      end
      // Past the cap, characters and dots are dropped but the label is
      // still skipped whole.
      if (text.size() != 0 && text.size() < NAME_CAP) text.push_back(DOT_CHAR);
      for (k = 0; k < c; k++) begin
        if (text.size() < NAME_CAP) text.push_back(peek_packet(pos + k));
      end
      pos += c;
    end
    if (bad) ok = 1'b0;
    // Running off the message without a pointer leaves ok low, which is
    // reported as a malformed name.
    nres = (text.size() + 3) / 4;
    if (nres == 0) nres = 1;
    for (k = 0; k < nres; k++) begin
      chunk = '0;
      for (i = 0; i < 4; i++) begin
        chunk.name_bytes = chunk.name_bytes << 8;
        if (k * 4 + i < text.size()) begin
          chunk.name_bytes[7:0] = text[k * 4 + i];
          chunk.byte_count      = chunk.byte_count + 3'd1;
        end
      end
      if (k + 1 == nres) begin
        chunk.last        = 1'b1;
        chunk.next_offset = ok ? ret[11:0] : 12'd0;
        chunk.status      = !ok;
      end
      walk_chunks.push_back(chunk);
    end
  endfunction

  function automatic plan_row_t load_row(input int unsigned addr, input logic [7:0] value);
    plan_row_t row;
    row            = '0;
    row.cmd        = dnsd_pkg::CMD_LOAD;
    row.offset     = addr[10:0];
    row.byte_value = value;
    row.msg_length = 12'($urandom_range(0, 4095));
    return row;
  endfunction

  function automatic plan_row_t decode_row(input int unsigned from_pos,
                                           input int unsigned msg_len);
    plan_row_t row;
    row            = '0;
    row.cmd        = dnsd_pkg::CMD_DECODE;
    row.offset     = from_pos[10:0];
    row.byte_value = 8'($urandom_range(0, 255));
    row.msg_length = msg_len[11:0];
    return row;
  endfunction

  // A decode row whose single result is written out by hand.
  function automatic plan_row_t typed_row(input int unsigned from_pos,
                                          input int unsigned msg_len,
                                          input logic [31:0] name_bytes,
                                          input logic [2:0] byte_count,
                                          input logic [11:0] next_offset,
                                          input logic status);
    plan_row_t row;
    row       = decode_row(from_pos, msg_len);
    row.typed = 1'b1;
    row.want  = '{name_bytes, byte_count, 1'b1, next_offset, status};
    return row;
  endfunction

  // Message length for a random decode: often the store size or fill_top,
  // sometimes above the store or short enough to cut the name or a pointer.
  function automatic int unsigned pick_len();
    int unsigned draw;
    draw = $urandom_range(0, 9);
    if (draw < 4) return MSG_BYTES;
    if (draw == 4) return $urandom_range(MSG_BYTES + 1, 4095);
    if (draw < 7) return fill_top;
    if (draw < 9) return $urandom_range(0, fill_top);
    return $urandom_range(fill_top, MSG_BYTES);
  endfunction

  // Presents one transaction and returns at the edge that accepts it. The
  // sender may first drop start for a random gap. For a decode, the caller
  // has already left the expected chunks in walk_chunks.
  task automatic send_cmd(input logic cmd, input int unsigned offset,
                          input logic [7:0] value, input int unsigned msg_len);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_offset     <= offset[10:0];
    in_byte_value <= value;
    in_msg_length <= msg_len[11:0];
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent_items++;
    if (cmd == dnsd_pkg::CMD_LOAD) begin
      packet_img[offset]   = value;
      packet_known[offset] = 1'b1;
      if (offset == fill_top) fill_top++;
    end else begin
      foreach (walk_chunks[n]) chunks_due.push_back(walk_chunks[n]);
    end
  endtask

  task automatic load_byte(input int unsigned addr, input logic [7:0] value);
    send_cmd(dnsd_pkg::CMD_LOAD, addr, value, $urandom_range(0, 4095));
  endtask

  task automatic append_byte(input logic [7:0] value);
    load_byte(fill_top, value);
  endtask

  // A decode that would read a byte never loaded is shortened to the loaded
  // region, where every read is safe.
  task automatic send_decode(input int unsigned from_pos, input int unsigned msg_len);
    int unsigned len_used;
    len_used = msg_len;
    walk_name(from_pos, len_used);
    if (walk_hit_unknown) begin
      len_used = fill_top;
      walk_name(from_pos, len_used);
    end
    send_cmd(dnsd_pkg::CMD_DECODE, from_pos, $urandom_range(0, 255), len_used);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Results cannot be held off, so each one is taken at the edge that ends
  // its cycle and matched against the oldest chunk still owed.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (chunks_due.size() == 0) begin
        $display("%0t: result with no decode waiting: expected none got %h/%0d/%b/%0d/%b",
                 $time, out_name_bytes, out_byte_count, out_last, out_next_offset,
                 out_status);
        mismatches++;
      end else begin
        due_chunk = chunks_due.pop_front();
        compare_field("name_bytes", due_chunk.name_bytes, out_name_bytes);
        compare_field("byte_count", due_chunk.byte_count, out_byte_count);
        compare_field("last", due_chunk.last, out_last);
        compare_field("next_offset", due_chunk.next_offset, out_next_offset);
        compare_field("status", due_chunk.status, out_status);
      end
    end
  end

  // Any cycle in which a transaction is taken or a result comes out counts
  // as progress. A long run without either means the block is stuck.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned draw, pick, head, labels, span, tgt, spot, hi, j, i, done;
    logic [7:0]  val;

    // Directed packet, laid down from offset 0:
    //   0  "ab" as a plain name       4  pointer to 0
    //   6  one-byte label, then a pointer back to 6 (a loop that grows the name)
    //   10 pointer to 4, so two jumps reach "ab"
    //   12 pointer to the highest 14-bit target, far past any message
    // plus a lone pointer byte in the last store position.
    plan.push_back(load_row(0, 8'h02));
    plan.push_back(load_row(1, 8'h61));
    plan.push_back(load_row(2, 8'h62));
    plan.push_back(load_row(3, 8'h00));
    plan.push_back(load_row(4, 8'hC0));
    plan.push_back(load_row(5, 8'h00));
    plan.push_back(load_row(6, 8'h01));
    plan.push_back(load_row(7, 8'hFF));
    plan.push_back(load_row(8, 8'hC0));
    plan.push_back(load_row(9, 8'h06));
    plan.push_back(load_row(10, 8'hC0));
    plan.push_back(load_row(11, 8'h04));
    plan.push_back(load_row(12, 8'hFF));
    plan.push_back(load_row(13, 8'hFF));
    plan.push_back(load_row(2047, 8'hC0));
    // The empty name.
    plan.push_back(typed_row(3, 2048, 32'h0, 3'd0, 12'd4, 1'b0));
    // A plain name, with the length above the store and clamped.
    plan.push_back(typed_row(0, 4095, 32'h61620000, 3'd2, 12'd4, 1'b0));
    // Two jumps; the name ends just past the first pointer.
    plan.push_back(typed_row(10, 2048, 32'h61620000, 3'd2, 12'd12, 1'b0));
    // A loop through a label: the name is cut, then the jump limit trips.
    plan.push_back(decode_row(6, 2048));
    // A jump off the end of the message still counts as a good name.
    plan.push_back(typed_row(12, 2048, 32'h0, 3'd0, 12'd14, 1'b0));
    // Running off the end with no jump taken is malformed, but the
    // characters already gathered still come out.
    plan.push_back(typed_row(0, 3, 32'h61620000, 3'd2, 12'd0, 1'b1));
    // A label that runs past the message.
    plan.push_back(typed_row(0, 2, 32'h0, 3'd0, 12'd0, 1'b1));
    // A pointer in the last valid byte has no second byte.
    plan.push_back(typed_row(4, 5, 32'h0, 3'd0, 12'd0, 1'b1));
    plan.push_back(typed_row(2047, 4095, 32'h0, 3'd0, 12'd0, 1'b1));
    // A zero-length message yields an empty name reported as malformed.
    plan.push_back(typed_row(0, 0, 32'h0, 3'd0, 12'd0, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].cmd == dnsd_pkg::CMD_DECODE) begin
        if (plan[r].typed) begin
          walk_chunks.delete();
          walk_chunks.push_back(plan[r].want);
        end else begin
          walk_name(plan[r].offset, plan[r].msg_length);
        end
        name_heads.push_back(plan[r].offset);
      end
      send_cmd(plan[r].cmd, plan[r].offset, plan[r].byte_value, plan[r].msg_length);
    end

    // Random traffic in three equal stretches: light sender gaps, heavy
    // sender gaps, then back-to-back transactions.
    while (sent_items < plan.size() + RANDOM_ITEMS) begin
      done = sent_items - plan.size();
      if (done < RANDOM_ITEMS / 3) idle_pct = 17;
      else if (done < 2 * RANDOM_ITEMS / 3) idle_pct = 69;
      else idle_pct = 0;
      draw = $urandom_range(0, 99);
      if (draw < 25) begin
        // Append a fresh name: a few labels of random bytes, ended by a zero
        // or by a pointer to an earlier name, into the region, or far away.
        head   = fill_top;
        labels = $urandom_range(0, 4);
        for (j = 0; j < labels; j++) begin
          span = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 6);
          append_byte(span[7:0]);
          for (i = 0; i < span; i++) append_byte(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          append_byte(8'h00);
        end else begin
          if (pick < 16) tgt = name_heads[$urandom_range(0, name_heads.size() - 1)];
          else if (pick < 18) tgt = $urandom_range(0, fill_top - 1);
          else tgt = $urandom_range(0, 16383);
          append_byte({dnsd_pkg::PTR_TAG, tgt[13:8]});
          append_byte(tgt[7:0]);
        end
        name_heads.push_back(head);
        if ($urandom_range(0, 1) == 1) send_decode(head, pick_len());
      end else if (draw < 70) begin
        send_decode(name_heads[$urandom_range(0, name_heads.size() - 1)], pick_len());
      end else if (draw < 80) begin
        send_decode($urandom_range(0, MSG_BYTES - 1), pick_len());
      end else begin
        // Overwrite one byte inside the loaded region. Long labels, zeros
        // and pointers dropped into existing names make malformed names,
        // long skips and new loops.
        spot = $urandom_range(0, fill_top - 1);
        pick = $urandom_range(0, 4);
        if (pick == 0) begin
          val = 8'hBF;
        end else if (pick == 1) begin
          val = 8'($urandom_range(1, 8'hBF));
        end else if (pick == 2) begin
          hi  = $urandom_range(0, fill_top >> 8);
          val = {dnsd_pkg::PTR_TAG, hi[5:0]};
        end else if (pick == 3) begin
          val = 8'h00;
        end else begin
          val = 8'($urandom_range(0, 255));
        end
        load_byte(spot, val);
        if ($urandom_range(0, 1) == 1) send_decode(spot, pick_len());
      end
    end

    start <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    // Watch a little longer for results nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
